### rtl/core/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Types and constants shared by the flight supervisor state machine unit.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam int unsigned FLAGS_W = 7;
	localparam int unsigned STATE_W = 4;

	localparam int unsigned FLG_ARMED    = 0;
	localparam int unsigned FLG_FLYING   = 1;
	localparam int unsigned FLG_TUMBLED  = 2;
	localparam int unsigned FLG_CHARGER  = 3;
	localparam int unsigned FLG_ESTOP    = 4;
	localparam int unsigned FLG_WDT_WARN = 5;
	localparam int unsigned FLG_WDT_TOUT = 6;

	localparam logic [FLAGS_W-1:0] MASK_BAD  = 7'b001_1100;
	localparam logic [FLAGS_W-1:0] MASK_FALL = 7'b101_0100;
	localparam logic [FLAGS_W-1:0] MASK_WDT  = 7'b110_0000;

	typedef logic [FLAGS_W-1:0] flags_t;

	typedef enum logic [STATE_W-1:0] {
		ST_NOTPASSED = 4'd0,
		ST_PASSED    = 4'd1,
		ST_READY     = 4'd2,
		ST_FLYING    = 4'd3,
		ST_LANDED    = 4'd4,
		ST_RESET     = 4'd5,
		ST_WARNING   = 4'd6,
		ST_FREEFALL  = 4'd7,
		ST_LOCKED    = 4'd8
	} state_t;

endpackage

### rtl/core/fss_next_state.sv
// ----------------------------------------------------------------------------
// fss_next_state
// Transition rules of the supervisor: first matching rule of the current
// state wins, otherwise the state holds.
// ----------------------------------------------------------------------------
module fss_next_state (
	input  fss_pkg::state_t cur_state,
	input  fss_pkg::flags_t flags,
	output fss_pkg::state_t nxt_state
);
	import fss_pkg::*;

	logic bad;
	logic armed;
	logic flying;
	logic fall;
	logic wdt_warn;
	logic wdt_any;

	assign bad      = |(flags & MASK_BAD);
	assign armed    = flags[FLG_ARMED];
	assign flying   = flags[FLG_FLYING];
	assign fall     = (|(flags & MASK_FALL)) || !armed;
	assign wdt_warn = flags[FLG_WDT_WARN];
	assign wdt_any  = |(flags & MASK_WDT);

	always_comb begin
		nxt_state = cur_state;
		unique case (cur_state)
			ST_NOTPASSED: begin
				if (!bad) nxt_state = ST_PASSED;
			end
			ST_PASSED: begin
				if (bad) nxt_state = ST_NOTPASSED;
				else if (armed) nxt_state = ST_READY;
			end
			ST_READY: begin
				if (bad || !armed) nxt_state = ST_NOTPASSED;
				else if (flying) nxt_state = ST_FLYING;
			end
			ST_FLYING: begin
				if (fall) nxt_state = ST_FREEFALL;
				else if (wdt_warn) nxt_state = ST_WARNING;
				else if (!flying) nxt_state = ST_LANDED;
			end
			ST_WARNING: begin
				if (fall) nxt_state = ST_FREEFALL;
				else if (!wdt_any) nxt_state = ST_FLYING;
			end
			ST_LANDED:   nxt_state = ST_RESET;
			ST_RESET:    nxt_state = ST_NOTPASSED;
			ST_FREEFALL: nxt_state = ST_LOCKED;
			ST_LOCKED:   nxt_state = ST_LOCKED;
			default:     nxt_state = cur_state;
		endcase
	end

endmodule

### rtl/core/flight_supervisor_state_machine_unit.sv
// ----------------------------------------------------------------------------
// flight_supervisor_state_machine_unit
// Result path: input register, then result register.
// Throughput: one tick per cycle while the output is accepted; the state update is a single registered step.
// Reset: supervisor state returns to checks not passed, both stages empty.
// ----------------------------------------------------------------------------
module flight_supervisor_state_machine_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [6:0] condition_flags
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [3:0] next_state, [4] state_changed
);
	import fss_pkg::*;

	logic   valid_s1;
	flags_t flags_s1;
	logic   valid_s2;
	state_t next_s2;
	logic   changed_s2;
	state_t state_q;
	state_t nxt_state;
	logic   adv_s1;

	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;

	fss_next_state u_next (
		.cur_state (state_q),
		.flags     (flags_s1),
		.nxt_state (nxt_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			flags_s1 <= s_axis_tdata[FLAGS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_NOTPASSED;
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) state_q <= nxt_state;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			next_s2    <= nxt_state;
			changed_s2 <= (nxt_state != state_q);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, changed_s2, next_s2};

`ifndef NO_ASSERTIONS
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[STATE_W-1:0] == state_q))
		else $error("result state differs from held state");

	a_locked_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOCKED) |=> (state_q == ST_LOCKED))
		else $error("locked state left");

	a_freefall_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FREEFALL) |=> (state_q == ST_FREEFALL || state_q == ST_LOCKED))
		else $error("free fall left for a state other than locked");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled without a full pipeline");
`endif

endmodule

### bench/tb_flight_supervisor_state_machine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flight_supervisor_state_machine_unit
// Streams condition flags into the supervisor and checks every tick's next
// state and change flag against a local prediction of the state machine. A
// directed walk through each rule is followed by random flag sets that steer
// the machine through its flight cycle, ending in free fall and lock, with
// random idling on both streams, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_flight_supervisor_state_machine_unit;

	import fss_pkg::*;

	typedef struct packed {
		logic       hold_for_drain;
		logic [7:0] payload;
	} stim_t;

	typedef struct packed {
		state_t next_state;
		logic   state_changed;
	} tick_t;

	localparam flags_t F_ARMED = flags_t'(1 << FLG_ARMED);
	localparam flags_t F_FLY   = flags_t'(1 << FLG_FLYING);
	localparam flags_t F_TUMB  = flags_t'(1 << FLG_TUMBLED);
	localparam flags_t F_CHG   = flags_t'(1 << FLG_CHARGER);
	localparam flags_t F_ESTOP = flags_t'(1 << FLG_ESTOP);
	localparam flags_t F_WARN  = flags_t'(1 << FLG_WDT_WARN);
	localparam flags_t F_TOUT  = flags_t'(1 << FLG_WDT_TOUT);
	localparam flags_t F_ALL   = '1;

	localparam int RANDOM_ITEMS = 425;
	localparam int TAIL_ITEMS   = 60;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = '0;  // [6:0] condition_flags
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;        // [3:0] next_state, [4] state_changed

	stim_t  flag_feed[$];
	tick_t  expected_ticks[$];
	stim_t  next_item;
	tick_t  want;
	state_t model_state;
	int     total_items = 0;
	int     fail_count = 0;
	int     ticks_checked = 0;
	int     changes_seen = 0;
	logic [8:0] states_visited = '0;

	int tx_sent = 0, tx_gap = 0, tx_cycle = 0;
	bit tx_calm = 1'b0;
	int rx_count = 0, rx_gap = 0, rx_cycle = 0, hold_left = 0;
	bit rx_calm = 1'b0, long_hold_done = 1'b0;

	flight_supervisor_state_machine_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic state_t advance_supervisor(input state_t cur, input flags_t f);
		logic bad;
		logic fall;
		bad = |(f & MASK_BAD);
		fall = (|(f & MASK_FALL)) || !f[FLG_ARMED];
		advance_supervisor = cur;
		case (cur)
			ST_NOTPASSED: begin
				if (!bad) advance_supervisor = ST_PASSED;
			end
			ST_PASSED: begin
				if (bad) advance_supervisor = ST_NOTPASSED;
				else if (f[FLG_ARMED]) advance_supervisor = ST_READY;
			end
			ST_READY: begin
				if (bad || !f[FLG_ARMED]) advance_supervisor = ST_NOTPASSED;
				else if (f[FLG_FLYING]) advance_supervisor = ST_FLYING;
			end
			ST_FLYING: begin
				if (fall) advance_supervisor = ST_FREEFALL;
				else if (f[FLG_WDT_WARN]) advance_supervisor = ST_WARNING;
				else if (!f[FLG_FLYING]) advance_supervisor = ST_LANDED;
			end
			ST_WARNING: begin
				if (fall) advance_supervisor = ST_FREEFALL;
				else if (!(|(f & MASK_WDT))) advance_supervisor = ST_FLYING;
			end
			ST_LANDED: advance_supervisor = ST_RESET;
			ST_RESET: advance_supervisor = ST_NOTPASSED;
			ST_FREEFALL: advance_supervisor = ST_LOCKED;
			default: ;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			tx_cycle++;
			if (tx_cycle % 64 == 0) tx_calm = ($urandom_range(0, 2) == 0);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) tx_sent++;
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (flag_feed.size() == 0 || (flag_feed[0].hold_for_drain &&
						(s_axis_tvalid || expected_ticks.size() != 0))) begin
					s_axis_tvalid <= 1'b0;
				end else if (tx_sent < total_items - TAIL_ITEMS && !tx_calm &&
						$urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(0, 12);
					s_axis_tvalid <= 1'b0;
				end else begin
					next_item = flag_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_item.payload;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
			if (m_axis_tvalid && m_axis_tready) rx_count++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && rx_count >= 150) begin
				long_hold_done = 1'b1;
				hold_left = 79;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else if (rx_count < total_items - TAIL_ITEMS && !rx_calm &&
					$urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor and prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_state = ST_NOTPASSED;
			expected_ticks.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_ticks.size() == 0) begin
					$error("result with no tick outstanding: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_ticks.pop_front();
					ticks_checked++;
					if (m_axis_tdata[STATE_W-1:0] !== want.next_state) begin
						$error("next_state: expected %0d, got %0d",
							want.next_state, m_axis_tdata[STATE_W-1:0]);
						fail_count++;
					end
					if (m_axis_tdata[STATE_W] !== want.state_changed) begin
						$error("state_changed: expected %0d, got %0d",
							want.state_changed, m_axis_tdata[STATE_W]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want.next_state = advance_supervisor(model_state,
					flags_t'(s_axis_tdata[FLAGS_W-1:0]));
				want.state_changed = (want.next_state != model_state);
				if (want.state_changed) changes_seen++;
				states_visited[want.next_state] = 1'b1;
				model_state = want.next_state;
				expected_ticks.push_back(want);
			end
		end
	end

	// stimulus and end of run
	initial begin
		flags_t opening[25];
		flags_t f;
		state_t plan_state;
		stim_t  item;
		int     i;
		int     cause;

		opening = '{F_ALL, '0, F_CHG, F_ARMED | F_FLY | F_WARN | F_TOUT, '0,
			F_ESTOP | F_ARMED, F_TUMB, F_ARMED, F_ARMED, F_ARMED, '0, '0, F_ARMED,
			F_ARMED | F_TUMB, '0, F_ARMED, F_ARMED | F_FLY, F_ARMED | F_FLY | F_CHG,
			F_ARMED | F_FLY | F_WARN, F_ARMED | F_WARN, F_ARMED | F_FLY, F_ARMED,
			F_ALL, '0, F_CHG};
		plan_state = ST_NOTPASSED;

		for (i = 0; i < 25; i++) begin
			// set the pad bit on the last two to show it is ignored
			item.payload = {i >= 23, opening[i]};
			item.hold_for_drain = 1'b0;
			flag_feed.push_back(item);
			plan_state = advance_supervisor(plan_state, opening[i]);
		end

		// steer towards flight; keep out of free fall until the end
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			f = flags_t'($urandom_range(0, 127));
			case (plan_state)
				ST_NOTPASSED: begin
					if ($urandom_range(0, 3) != 0) f &= ~MASK_BAD;
				end
				ST_PASSED, ST_READY: begin
					if ($urandom_range(0, 3) != 0) begin
						f &= ~MASK_BAD;
						f[FLG_ARMED] = 1'b1;
					end
				end
				ST_FLYING, ST_WARNING: begin
					f &= ~MASK_FALL;
					f[FLG_ARMED] = 1'b1;
				end
				default: ;
			endcase
			item.payload = {1'b0, f};
			item.hold_for_drain = (i == 0 || i == 280);
			flag_feed.push_back(item);
			plan_state = advance_supervisor(plan_state, f);
		end

		while (plan_state != ST_FLYING && plan_state != ST_WARNING) begin
			f = flags_t'($urandom_range(0, 127));
			if (plan_state == ST_NOTPASSED || plan_state == ST_PASSED ||
					plan_state == ST_READY) begin
				f &= ~MASK_BAD;
				f[FLG_ARMED] = 1'b1;
				f[FLG_FLYING] = 1'b1;
			end
			item.payload = {1'b0, f};
			item.hold_for_drain = 1'b0;
			flag_feed.push_back(item);
			plan_state = advance_supervisor(plan_state, f);
		end

		// drop into free fall by one of its causes, then sit locked
		f = flags_t'($urandom_range(0, 127));
		cause = $urandom_range(0, 3);
		case (cause)
			0: f[FLG_ARMED] = 1'b0;
			1: f[FLG_TUMBLED] = 1'b1;
			2: f[FLG_ESTOP] = 1'b1;
			default: f[FLG_WDT_TOUT] = 1'b1;
		endcase
		item.payload = {1'b0, f};
		flag_feed.push_back(item);
		for (i = 0; i < 8; i++) begin
			item.payload = {1'b0, flags_t'($urandom_range(0, 127))};
			flag_feed.push_back(item);
		end
		total_items = flag_feed.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (flag_feed.size() != 0 || s_axis_tvalid || expected_ticks.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Checked %0d ticks with %0d state changes; states reached (8..0): %b",
			ticks_checked, changes_seen, states_visited);
		if (fail_count == 0 && expected_ticks.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
